/* hw/rtl/box_avg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package box_avg_pkg;

	localparam int unsigned MAX_SOURCE_WIDTH  = 4096;
	localparam int unsigned MAX_SOURCE_HEIGHT = 4096;
	localparam int unsigned MAX_TARGET_WIDTH  = 2048;
	localparam int unsigned COL_AW = $clog2(MAX_TARGET_WIDTH);

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
	localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       image_done;
	} res_t;

	// One column accumulator as held in the column memory.
	typedef struct packed {
		logic [31:0] red_sum;
		logic [31:0] green_sum;
		logic [31:0] blue_sum;
		logic [24:0] count;
	} acc_t;

	// Per-pixel control carried from the accept cycle to the update cycle.
	typedef struct packed {
		logic [COL_AW-1:0] tcol;
		logic              emit;
		logic              fresh;
		logic              done;
	} ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RMW,
		ST_DIV,
		ST_OUT
	} state_t;

	function automatic logic [12:0] eff_src(input logic [12:0] v, input logic [12:0] hi);
		logic [12:0] r;
		if (v == 13'd0) r = 13'd1;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/box_avg_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module box_avg_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hw/rtl/box_average_image_downscaler.sv */
`timescale 1ns / 1ps
`default_nettype none
// Box-average image downscaler. Source pixels arrive in raster order on the input channel,
// one transaction per pixel; the source is cut into target_width by target_height boxes
// with edges at floor(i*S/D), and when the last pixel of a box arrives the block returns
// the truncated per-channel average of that box, with image_done set on the last box of
// the image. Sizes are clamped so that the output is never larger than the source. Any
// write to a size register restarts the image; write sizes only while the block is idle.
// A pixel that does not close a box is accepted, which reads its column accumulator from
// the column memory, and then added in with the entry written back. A pixel that closes
// a box also goes through the 8-step shared divider (one quotient bit per cycle for all
// three channels) and a final step that moves the result into the output register. The
// output register lets the next pixel be accepted while a result waits. After reset and
// after each register write the block takes no pixel until the restart has loaded the
// raster position and error terms. The column memory is never cleared: the first pixel
// of a box on the first row of a row box overwrites whatever the entry held.
module box_average_image_downscaler (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire box_avg_pkg::pix_t      in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output box_avg_pkg::res_t           out_data,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [3:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int unsigned AW = box_avg_pkg::COL_AW;

	// Configuration registers.
	logic [12:0] src_w_q, src_h_q, dst_h_q;
	logic [11:0] dst_w_q;
	logic        restart_q;

	// Effective sizes after clamping.
	logic [12:0] sw, sh, dh, dw_hi;
	logic [11:0] dw;

	// Raster position and box error terms.
	logic [11:0] x_q, y_q;
	logic [AW-1:0] tcol_q;
	logic [11:0] trow_q;
	logic signed [14:0] dc_q, dr_q;
	logic col_first_q, row_first_q;

	box_avg_pkg::state_t state_q, state_d;
	box_avg_pkg::pix_t   pix_s1;
	box_avg_pkg::ctl_t   ctl_s1;
	box_avg_pkg::res_t   out_q;
	logic                out_valid_q;

	// Divider.
	logic [31:0] rem_q [3];
	logic [7:0]  quo_q [3];
	logic [24:0] cnt_q;
	logic [2:0]  step_q;
	logic        done_q;

	logic        accept, cfg_wr, col_last, row_last;
	logic        ram_we;
	box_avg_pkg::acc_t rd_acc, base_acc, new_acc;
	logic [31:0] den;
	logic [31:0] rem_next [3];
	logic        ge [3];
	logic signed [14:0] dc_init, dr_init;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign accept = in_valid && in_ready;

	always_comb begin
		sw = box_avg_pkg::eff_src(src_w_q, 13'(box_avg_pkg::MAX_SOURCE_WIDTH));
		sh = box_avg_pkg::eff_src(src_h_q, 13'(box_avg_pkg::MAX_SOURCE_HEIGHT));
		dw_hi = (sw > 13'(box_avg_pkg::MAX_TARGET_WIDTH)) ?
			13'(box_avg_pkg::MAX_TARGET_WIDTH) : sw;
		dw = 12'(box_avg_pkg::eff_src({1'b0, dst_w_q}, dw_hi));
		dh = box_avg_pkg::eff_src(dst_h_q, sh);
		// Error term (x+2)*d - (i+1)*s at the start of a row or image; a pixel is the
		// last of its box when the term is positive.
		dc_init = $signed({2'b00, dw, 1'b0}) - $signed({2'b00, sw});
		dr_init = $signed({1'b0, dh, 1'b0}) - $signed({2'b00, sh});
	end

	always_comb begin
		case (paddr[3:2])
			box_avg_pkg::REG_SOURCE_WIDTH:  prdata = {19'd0, src_w_q};
			box_avg_pkg::REG_SOURCE_HEIGHT: prdata = {19'd0, src_h_q};
			box_avg_pkg::REG_TARGET_WIDTH:  prdata = {20'd0, dst_w_q};
			box_avg_pkg::REG_TARGET_HEIGHT: prdata = {19'd0, dst_h_q};
			default:                        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 13'd1;
			src_h_q <= 13'd1;
			dst_w_q <= 12'd1;
			dst_h_q <= 13'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				box_avg_pkg::REG_SOURCE_WIDTH:  src_w_q <= pwdata[12:0];
				box_avg_pkg::REG_SOURCE_HEIGHT: src_h_q <= pwdata[12:0];
				box_avg_pkg::REG_TARGET_WIDTH:  dst_w_q <= pwdata[11:0];
				box_avg_pkg::REG_TARGET_HEIGHT: dst_h_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	assign col_last = dc_q > 15'sd0;
	assign row_last = dr_q > 15'sd0;

	// Raster tracking. A register write sets restart_q, and the restart is applied from
	// that register so that the initial error terms see the new sizes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q   <= 1'b1;
			x_q         <= '0;
			y_q         <= '0;
			tcol_q      <= '0;
			trow_q      <= '0;
			dc_q        <= '0;
			dr_q        <= '0;
			col_first_q <= 1'b1;
			row_first_q <= 1'b1;
		end else if (cfg_wr) begin
			restart_q <= 1'b1;
		end else if (restart_q) begin
			restart_q   <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			tcol_q      <= '0;
			trow_q      <= '0;
			dc_q        <= dc_init;
			dr_q        <= dr_init;
			col_first_q <= 1'b1;
			row_first_q <= 1'b1;
		end else if (accept) begin
			if (col_last) begin
				col_first_q <= 1'b1;
				if ({1'b0, x_q} + 13'd1 == sw) begin
					x_q    <= '0;
					tcol_q <= '0;
					dc_q   <= dc_init;
					if ({1'b0, y_q} + 13'd1 == sh) begin
						y_q         <= '0;
						trow_q      <= '0;
						dr_q        <= dr_init;
						row_first_q <= 1'b1;
					end else begin
						y_q <= y_q + 12'd1;
						if (row_last) begin
							trow_q      <= trow_q + 12'd1;
							dr_q        <= dr_q + $signed({2'b00, dh}) - $signed({2'b00, sh});
							row_first_q <= 1'b1;
						end else begin
							dr_q        <= dr_q + $signed({2'b00, dh});
							row_first_q <= 1'b0;
						end
					end
				end else begin
					x_q    <= x_q + 12'd1;
					tcol_q <= tcol_q + AW'(1);
					dc_q   <= dc_q + $signed({3'b000, dw}) - $signed({2'b00, sw});
				end
			end else begin
				x_q         <= x_q + 12'd1;
				dc_q        <= dc_q + $signed({3'b000, dw});
				col_first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= in_data;
			ctl_s1.tcol  <= tcol_q;
			ctl_s1.emit  <= col_last && row_last;
			ctl_s1.fresh <= col_first_q && row_first_q;
			ctl_s1.done  <= ({1'b0, tcol_q} + 12'd1 >= dw) &&
				({1'b0, trow_q} + 13'd1 >= dh);
		end
	end

	// Column memory: read-modify-write in the cycle after acceptance. The write lands
	// before the next pixel's read, so no forwarding is needed.
	box_avg_ram #(
		.WIDTH($bits(box_avg_pkg::acc_t)),
		.DEPTH(box_avg_pkg::MAX_TARGET_WIDTH)
	) u_col_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ctl_s1.tcol),
		.wdata(new_acc),
		.raddr(tcol_q),
		.rdata(rd_acc)
	);

	always_comb begin
		base_acc = ctl_s1.fresh ? '0 : rd_acc;
		new_acc.red_sum   = base_acc.red_sum + {24'd0, pix_s1.red_in};
		new_acc.green_sum = base_acc.green_sum + {24'd0, pix_s1.green_in};
		new_acc.blue_sum  = base_acc.blue_sum + {24'd0, pix_s1.blue_in};
		new_acc.count     = base_acc.count + 25'd1;
		ram_we = (state_q == box_avg_pkg::ST_RMW);
	end

	// Divider: restoring, one quotient bit per cycle, MSB first. The quotient of an
	// average never exceeds eight bits.
	always_comb begin
		den = 32'({7'd0, cnt_q} << step_q);
		for (int k = 0; k < 3; k++) begin
			ge[k]       = rem_q[k] >= den;
			rem_next[k] = ge[k] ? rem_q[k] - den : rem_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == box_avg_pkg::ST_RMW) begin
			rem_q[0] <= new_acc.red_sum;
			rem_q[1] <= new_acc.green_sum;
			rem_q[2] <= new_acc.blue_sum;
			cnt_q    <= new_acc.count;
			done_q   <= ctl_s1.done;
			step_q   <= 3'd7;
		end else if (state_q == box_avg_pkg::ST_DIV) begin
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= rem_next[k];
				quo_q[k] <= {quo_q[k][6:0], ge[k]};
			end
			step_q <= step_q - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= box_avg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			box_avg_pkg::ST_IDLE: begin
				in_ready = !restart_q;
				if (accept) state_d = box_avg_pkg::ST_RMW;
			end
			box_avg_pkg::ST_RMW: begin
				state_d = ctl_s1.emit ? box_avg_pkg::ST_DIV : box_avg_pkg::ST_IDLE;
			end
			box_avg_pkg::ST_DIV: begin
				if (step_q == 3'd0) state_d = box_avg_pkg::ST_OUT;
			end
			box_avg_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = box_avg_pkg::ST_IDLE;
			end
			default: state_d = box_avg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == box_avg_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == box_avg_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
			out_q.red_out    <= quo_q[0];
			out_q.green_out  <= quo_q[1];
			out_q.blue_out   <= quo_q[2];
			out_q.image_done <= done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_accept_to_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == box_avg_pkg::ST_RMW)
		else $error("accepted pixel did not enter the update cycle");

	a_ram_write_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(accept))
		else $error("column memory written without a pixel");

	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == box_avg_pkg::ST_OUT))
		else $error("result appeared without a finished division");

	a_no_accept_restart: assert property (@(posedge clk) disable iff (!arst_n)
		restart_q |-> !in_ready)
		else $error("pixel taken before restart completed");
`endif

endmodule
`default_nettype wire

/* test/box_average_image_downscaler_tb.sv */
`timescale 1ns / 1ps
module box_average_image_downscaler_tb;

	// Clock and reset.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Block ports.
	logic                in_valid = 1'b0;
	logic                in_ready;
	box_avg_pkg::pix_t   in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	box_avg_pkg::res_t   out_data;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [3:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	box_average_image_downscaler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: the size registers as written, the column accumulators and the
	// raster position of the image currently being scanned.
	logic [12:0] src_w_reg, src_h_reg, dst_h_reg;
	logic [11:0] dst_w_reg;
	int unsigned col_red[box_avg_pkg::MAX_TARGET_WIDTH];
	int unsigned col_green[box_avg_pkg::MAX_TARGET_WIDTH];
	int unsigned col_blue[box_avg_pkg::MAX_TARGET_WIDTH];
	int unsigned col_count[box_avg_pkg::MAX_TARGET_WIDTH];
	int unsigned src_col, src_row, dst_col, dst_row, col_edge, row_edge;

	box_avg_pkg::res_t expected_pixels[$];
	box_avg_pkg::pix_t pixel_queue[$];
	int          mismatches = 0;
	longint      cycle_count = 0;

	function automatic void queue_pixel(box_avg_pkg::pix_t p);
		pixel_queue.insert(pixel_queue.size(), p);
	endfunction

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned eff_sw();
		return clamp_dim(src_w_reg, box_avg_pkg::MAX_SOURCE_WIDTH);
	endfunction

	function automatic int unsigned eff_sh();
		return clamp_dim(src_h_reg, box_avg_pkg::MAX_SOURCE_HEIGHT);
	endfunction

	function automatic int unsigned eff_dw();
		int unsigned hi;
		hi = eff_sw();
		if (hi > box_avg_pkg::MAX_TARGET_WIDTH) hi = box_avg_pkg::MAX_TARGET_WIDTH;
		return clamp_dim(dst_w_reg, hi);
	endfunction

	function automatic int unsigned eff_dh();
		return clamp_dim(dst_h_reg, eff_sh());
	endfunction

	// Exclusive end of box idx when s source positions are split into d boxes.
	function automatic int unsigned box_limit(int unsigned idx, int unsigned s,
			int unsigned d);
		longint unsigned v;
		v = (longint'(idx) + 1) * longint'(s);
		return int'(v / d);
	endfunction

	function automatic void restart_scan();
		for (int i = 0; i < box_avg_pkg::MAX_TARGET_WIDTH; i++) begin
			col_red[i] = 0;
			col_green[i] = 0;
			col_blue[i] = 0;
			col_count[i] = 0;
		end
		src_col = 0;
		src_row = 0;
		dst_col = 0;
		dst_row = 0;
		col_edge = box_limit(0, eff_sw(), eff_dw());
		row_edge = box_limit(0, eff_sh(), eff_dh());
	endfunction

	// Adds one source pixel to its column box and queues the average when it closes a box.
	function automatic void accumulate_pixel(box_avg_pkg::pix_t p);
		int unsigned sw, sh, dw, dh, tc, c;
		bit col_last, row_last;
		box_avg_pkg::res_t r;
		sw = eff_sw();
		sh = eff_sh();
		dw = eff_dw();
		dh = eff_dh();
		tc = dst_col;
		col_red[tc] += p.red_in;
		col_green[tc] += p.green_in;
		col_blue[tc] += p.blue_in;
		col_count[tc] = (col_count[tc] + 1) & 32'h1FF_FFFF;
		col_last = src_col + 1 >= col_edge;
		row_last = src_row + 1 >= row_edge;
		if (col_last && row_last) begin
			c = col_count[tc];
			r.red_out = 8'(col_red[tc] / c);
			r.green_out = 8'(col_green[tc] / c);
			r.blue_out = 8'(col_blue[tc] / c);
			r.image_done = (tc + 1 >= dw) && (dst_row + 1 >= dh);
			expected_pixels.insert(expected_pixels.size(), r);
			col_red[tc] = 0;
			col_green[tc] = 0;
			col_blue[tc] = 0;
			col_count[tc] = 0;
		end
		if (col_last) begin
			if (src_col + 1 >= sw) begin
				src_col = 0;
				dst_col = 0;
				col_edge = box_limit(0, sw, dw);
				src_row++;
				if (row_last) begin
					dst_row++;
					row_edge = box_limit(dst_row, sh, dh);
				end
				if (src_row >= sh) begin
					src_row = 0;
					dst_row = 0;
					row_edge = box_limit(0, sh, dh);
				end
			end else begin
				src_col++;
				dst_col = tc + 1;
				col_edge = box_limit(dst_col, sw, dw);
			end
		end else begin
			src_col++;
		end
	endfunction

	// Driver: presents queued pixels with a random gap before each one. The prediction is
	// made when the transaction is accepted.
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				accumulate_pixel(in_data);
				void'(pixel_queue.pop_front());
				in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			end
			if (!(in_valid && !in_ready)) begin
				if (pixel_queue.size() > 0 && in_gap == 0) begin
					in_valid <= 1'b1;
					in_data <= pixel_queue[0];
				end else begin
					in_valid <= 1'b0;
					if (in_gap > 0) in_gap--;
				end
			end
		end
	end

	// Monitor: random backpressure and field-by-field comparison against the oldest
	// expected average.
	int out_gap = 0;
	always @(posedge clk) begin
		box_avg_pkg::res_t e;
		cycle_count++;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: got %p", out_data);
				end else begin
					e = expected_pixels.pop_front();
					if (out_data.red_out !== e.red_out || out_data.green_out !== e.green_out ||
							out_data.blue_out !== e.blue_out ||
							out_data.image_done !== e.image_done) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", e, out_data);
					end
				end
				out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
		if (cycle_count > 3000000) begin
			$display("box_average_image_downscaler_tb: done, errors");
			$finish;
		end
	end

	task automatic write_size(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			box_avg_pkg::REG_SOURCE_WIDTH: src_w_reg = value[12:0];
			box_avg_pkg::REG_SOURCE_HEIGHT: src_h_reg = value[12:0];
			box_avg_pkg::REG_TARGET_WIDTH: dst_w_reg = value[11:0];
			default: dst_h_reg = value[12:0];
		endcase
		restart_scan();
	endtask

	// Waits until every queued pixel went in and every expected average came out, then lets
	// any pixel still in the accumulate pipeline settle.
	task automatic drain();
		while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic box_avg_pkg::pix_t rand_pixel();
		box_avg_pkg::pix_t p;
		p = 24'($urandom());
		return p;
	endfunction

	task automatic run_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
			int unsigned dh, int unsigned n);
		write_size(box_avg_pkg::REG_SOURCE_WIDTH, sw);
		write_size(box_avg_pkg::REG_SOURCE_HEIGHT, sh);
		write_size(box_avg_pkg::REG_TARGET_WIDTH, dw);
		write_size(box_avg_pkg::REG_TARGET_HEIGHT, dh);
		for (int i = 0; i < n; i++) queue_pixel(rand_pixel());
		drain();
	endtask

	initial begin
		int unsigned sw, sh, n, total;
		src_w_reg = 1;
		src_h_reg = 1;
		dst_w_reg = 1;
		dst_h_reg = 1;
		restart_scan();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset sizes with channel extremes, so every pixel is its own box.
		queue_pixel('0);
		queue_pixel('1);
		queue_pixel(box_avg_pkg::pix_t'(24'hAA55AA));
		queue_pixel(box_avg_pkg::pix_t'(24'h55AA55));
		drain();
		// Zero sizes are taken as one, and an upscaling request clamps to the source.
		run_sizes(0, 0, 0, 0, 2);
		run_sizes(3, 2, 2047, 4095, 6);
		// A 4x3 source into 3x2 boxes of uneven size, all pixels at full scale.
		write_size(box_avg_pkg::REG_SOURCE_WIDTH, 4);
		write_size(box_avg_pkg::REG_SOURCE_HEIGHT, 3);
		write_size(box_avg_pkg::REG_TARGET_WIDTH, 3);
		write_size(box_avg_pkg::REG_TARGET_HEIGHT, 2);
		for (int i = 0; i < 12; i++) queue_pixel('1);
		drain();
		// Oversized source width clamps to the maximum; the start of a wide row.
		run_sizes(8191, 1, 4095, 1, 40);
		run_sizes(4096, 1, 2048, 1, 64);
		// Tall source into two-row boxes, and full width rows into a single output column.
		run_sizes(1, 4096, 1, 2048, 64);
		run_sizes(7, 3, 1, 3, 21);

		// Random: small images, one to three whole frames each.
		total = 0;
		while (total < 490) begin
			sw = $urandom_range(1, 12);
			sh = $urandom_range(1, 8);
			n = sw * sh * $urandom_range(1, 3);
			run_sizes(($urandom_range(0, 9) == 0) ? 0 : sw, sh,
				$urandom_range(0, sw + 2), $urandom_range(0, sh + 2), n);
			total += n;
		end

		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("box_average_image_downscaler_tb: done, clean");
		end else begin
			$display("box_average_image_downscaler_tb: done, errors");
		end
		$finish;
	end
endmodule

/* files.f */
hw/rtl/box_avg_pkg.sv
hw/rtl/box_avg_ram.sv
hw/rtl/box_average_image_downscaler.sv
test/box_average_image_downscaler_tb.sv
